// File: design/sorted_table_find_swap_or_insert_assert.svh
// Assertion macros for the sorted table block.
// Used by sorted_table_find_swap_or_insert.sv; expects clk and rst_n in scope.
`ifndef SORTED_TABLE_FIND_SWAP_OR_INSERT_ASSERT_SVH
`define SORTED_TABLE_FIND_SWAP_OR_INSERT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define STFSI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define STFSI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/stfsi_pkg.sv
// Package for the sorted table find/swap/insert block.
// Holds sequencer state and status codes plus fixed port widths; no dependencies.
package stfsi_pkg;

  localparam int KEY_W    = 32;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 6;
  localparam int ENT_W    = 7;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    STAT_SWAPPED  = 2'd0,
    STAT_LAST     = 2'd1,
    STAT_INSERTED = 2'd2,
    STAT_FULL     = 2'd3
  } status_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PROBE,
    ST_CMP,
    ST_SWAP_RD,
    ST_SWAP_A,
    ST_SWAP_B,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_PLACE,
    ST_FINISH
  } state_t;

endpackage

// File: design/sorted_table_find_swap_or_insert.sv
// Sorted key table with binary-search find, swap-with-successor and ordered insert.
// Depends on stfsi_pkg and sorted_table_find_swap_or_insert_assert.svh.
//
// Usage: one word on the input channel (in_valid/in_ready, in_key) yields exactly
// one result word on the output channel (out_valid/out_ready, out_status,
// out_position, out_entries). The block handles one word at a time; in_ready is
// high only while the sequencer is idle.
// Sequence after acceptance: each binary-search probe reads the table RAM, then
// compares, for at most floor(log2(CAPACITY)) + 1 probes. A hit then swaps the key
// with its successor (read, write down, write up), or does nothing on the last entry.
// A miss is seen as an exhausted search; an insert then moves every later entry up
// one place through the single RAM port, a read and a write per moved entry, then
// ends the move and writes the new key. The result register is loaded once the
// output register is free, and the sequencer returns to idle to accept the next word.
// Reset empties the table (count to zero) and drops any pending result; the
// table contents are not cleared and no clearing pass is needed.
// Output stall: a finished result waits in the output register; the next word can
// be accepted and searched meanwhile, and its result is held back until the
// output register is free.
`include "sorted_table_find_swap_or_insert_assert.svh"

module sorted_table_find_swap_or_insert #(
  parameter int CAPACITY = 64
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [stfsi_pkg::KEY_W-1:0]    in_key,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic        [stfsi_pkg::STATUS_W-1:0] out_status,
  output logic        [stfsi_pkg::POS_W-1:0]    out_position,
  output logic        [stfsi_pkg::ENT_W-1:0]    out_entries
);
  import stfsi_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  // Table RAM, one write and one registered read per cycle.
  logic signed [KEY_W-1:0] mem [CAPACITY];
  logic signed [KEY_W-1:0] rd_data_r;
  logic        [AW-1:0]    mem_raddr;
  logic        [AW-1:0]    mem_waddr;
  logic signed [KEY_W-1:0] mem_wdata;
  logic                    mem_we;

  state_t state_r, state_nxt;

  logic signed [KEY_W-1:0] key_r, key_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [CW-1:0]   left_r, left_nxt;
  logic [CW-1:0]   rplus_r, rplus_nxt;   // right bound plus one
  logic [AW-1:0]   mid_r, mid_nxt;
  logic [CW-1:0]   ptr_r, ptr_nxt;
  status_t         res_status_r, res_status_nxt;
  logic [POS_W-1:0] res_pos_r, res_pos_nxt;

  logic             out_valid_r, out_valid_nxt;
  status_t          out_status_r, out_status_nxt;
  logic [POS_W-1:0] out_pos_r, out_pos_nxt;
  logic [ENT_W-1:0] out_ent_r, out_ent_nxt;

  logic          in_fire;
  logic          search_live;
  logic [CW:0]   mid_sum;
  logic [AW-1:0] mid_calc;
  logic [CW-1:0] mid_ext;
  logic [CW-1:0] mid_inc;
  logic [CW-1:0] ptr_dec;
  logic          out_free;
  logic          tbl_full;

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign tbl_full = (count_r == CW'(CAPACITY));

  // Probe index (left + right) / 2 with right = rplus - 1.
  assign search_live = (left_r < rplus_r);
  assign mid_sum     = {1'b0, left_r} + {1'b0, rplus_r} - (CW+1)'(1);
  assign mid_calc    = mid_sum[AW:1];
  assign mid_ext     = CW'(mid_r);
  assign mid_inc     = mid_ext + CW'(1);
  assign ptr_dec     = ptr_r - CW'(1);

  // Table RAM write and registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) state_nxt = ST_PROBE;
      end
      ST_PROBE: begin
        if (search_live)   state_nxt = ST_CMP;
        else if (tbl_full) state_nxt = ST_FINISH;
        else               state_nxt = ST_SHIFT_RD;
      end
      ST_CMP: begin
        if (rd_data_r == key_r) begin
          state_nxt = (mid_inc < count_r) ? ST_SWAP_RD : ST_FINISH;
        end else begin
          state_nxt = ST_PROBE;
        end
      end
      ST_SWAP_RD:  state_nxt = ST_SWAP_A;
      ST_SWAP_A:   state_nxt = ST_SWAP_B;
      ST_SWAP_B:   state_nxt = ST_FINISH;
      ST_SHIFT_RD: state_nxt = (ptr_r > left_r) ? ST_SHIFT_WR : ST_PLACE;
      ST_SHIFT_WR: state_nxt = ST_SHIFT_RD;
      ST_PLACE:    state_nxt = ST_FINISH;
      ST_FINISH: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // Datapath control and register next values.
  always_comb begin
    key_nxt        = key_r;
    count_nxt      = count_r;
    left_nxt       = left_r;
    rplus_nxt      = rplus_r;
    mid_nxt        = mid_r;
    ptr_nxt        = ptr_r;
    res_status_nxt = res_status_r;
    res_pos_nxt    = res_pos_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_pos_nxt    = out_pos_r;
    out_ent_nxt    = out_ent_r;
    mem_raddr      = mid_calc;
    mem_waddr      = mid_r;
    mem_wdata      = key_r;
    mem_we         = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          key_nxt   = in_key;
          left_nxt  = '0;
          rplus_nxt = count_r;
        end
      end
      ST_PROBE: begin
        // Read the probe entry; on an exhausted search prepare the insert, or the full status.
        mid_nxt = mid_calc;
        ptr_nxt = count_r;
        if (!search_live && tbl_full) begin
          res_status_nxt = STAT_FULL;
          res_pos_nxt    = '0;
        end
      end
      ST_CMP: begin
        res_pos_nxt = POS_W'(mid_r);
        if (rd_data_r == key_r) begin
          res_status_nxt = (mid_inc < count_r) ? STAT_SWAPPED : STAT_LAST;
        end else if (rd_data_r < key_r) begin
          left_nxt = mid_inc;
        end else begin
          rplus_nxt = mid_ext;
        end
      end
      ST_SWAP_RD: begin
        mem_raddr = mid_inc[AW-1:0];
      end
      ST_SWAP_A: begin
        // Successor moves down into the matched slot.
        mem_we    = 1'b1;
        mem_waddr = mid_r;
        mem_wdata = rd_data_r;
      end
      ST_SWAP_B: begin
        // Matched value equals the key, so the key goes up one slot.
        mem_we    = 1'b1;
        mem_waddr = mid_inc[AW-1:0];
        mem_wdata = key_r;
      end
      ST_SHIFT_RD: begin
        mem_raddr = ptr_dec[AW-1:0];
      end
      ST_SHIFT_WR: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_r[AW-1:0];
        mem_wdata = rd_data_r;
        ptr_nxt   = ptr_dec;
      end
      ST_PLACE: begin
        mem_we         = 1'b1;
        mem_waddr      = left_r[AW-1:0];
        mem_wdata      = key_r;
        count_nxt      = count_r + CW'(1);
        res_status_nxt = STAT_INSERTED;
        res_pos_nxt    = POS_W'(left_r);
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_pos_nxt    = res_pos_r;
          out_ent_nxt    = ENT_W'(count_r);
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    key_r        <= key_nxt;
    left_r       <= left_nxt;
    rplus_r      <= rplus_nxt;
    mid_r        <= mid_nxt;
    ptr_r        <= ptr_nxt;
    res_status_r <= res_status_nxt;
    res_pos_r    <= res_pos_nxt;
    out_status_r <= out_status_nxt;
    out_pos_r    <= out_pos_nxt;
    out_ent_r    <= out_ent_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_position = out_pos_r;
  assign out_entries  = out_ent_r;

  // Accepting a word always starts the sequencer.
  `STFSI_ASSERT_NEXT(a_accept_starts, in_fire, state_r == ST_PROBE,
                     "accepted word did not start a search")
  // The table is only written in the swap, shift and place steps.
  `STFSI_ASSERT_NOW(a_write_states, mem_we,
                    state_r == ST_SWAP_A || state_r == ST_SWAP_B ||
                    state_r == ST_SHIFT_WR || state_r == ST_PLACE,
                    "table written outside a write step")
  // Placing a key grows the count by exactly one.
  `STFSI_ASSERT_NEXT(a_place_grows, state_r == ST_PLACE,
                     count_r == $past(count_r) + CW'(1),
                     "insert did not grow the count")
  // An insert is never attempted on a full table.
  `STFSI_ASSERT_NOW(a_no_overfill, state_r == ST_SHIFT_RD, !tbl_full,
                    "insert started on a full table")

endmodule
